// ===== design/one_shot_timer_pool_unit_assert.svh =====
// Assertion macros for the timer pool RTL (used by otp_ctrl).
`ifndef ONE_SHOT_TIMER_POOL_UNIT_ASSERT_SVH
`define ONE_SHOT_TIMER_POOL_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define OTP_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define OTP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/otp_pkg.sv =====
// Types and constants shared by the one-shot timer pool.
package otp_pkg;

	localparam int ID_W     = 8;
	localparam int PERIOD_W = 32;

	localparam logic [ID_W-1:0] NO_SLOT = 8'hFF;

	localparam logic [1:0] KIND_CREATE = 2'd0;
	localparam logic [1:0] KIND_QUERY  = 2'd1;
	localparam logic [1:0] KIND_EXPIRE = 2'd2;

	typedef enum logic [2:0] {
		REQ_CREATE = 3'd0,
		REQ_START  = 3'd1,
		REQ_STOP   = 3'd2,
		REQ_DELETE = 3'd3,
		REQ_QUERY  = 3'd4,
		REQ_TICK   = 3'd5,
		REQ_SCHED  = 3'd6
	} req_t;

	typedef enum logic [2:0] {
		ST_IDLE    = 3'd0,
		ST_CREATED = 3'd1,
		ST_RUNNING = 3'd2,
		ST_STOPPED = 3'd3,
		ST_DELETED = 3'd4
	} status_t;

	typedef enum logic {
		CS_IDLE = 1'b0,
		CS_PASS = 1'b1
	} ctl_state_t;

	// Request word that walks down the row of timer cells.
	typedef struct packed {
		logic                vld;
		req_t                op;
		logic [ID_W-1:0]     id;
		logic [PERIOD_W-1:0] period;
		logic                found;
		logic [ID_W-1:0]     got;
		logic                run;
	} tok_t;

endpackage

// ===== design/otp_cell.sv =====
// One timer slot: applies the passing request to its own state and hands it on.
module otp_cell #(
	parameter int IDX = 0
) (
	input  logic          clk,
	input  logic          arst_n,
	input  otp_pkg::tok_t tok_in,
	output otp_pkg::tok_t tok_q,
	output logic          hit
);
	import otp_pkg::*;

	localparam logic [ID_W-1:0] MY_ID = ID_W'(IDX);

	status_t             status_q, status_d;
	logic [PERIOD_W-1:0] period_q, period_d;
	logic [PERIOD_W-1:0] elapsed_q, elapsed_d;
	logic [PERIOD_W-1:0] elapsed_inc;
	logic                match;
	tok_t                tok_d;

	always_comb begin
		status_d    = status_q;
		period_d    = period_q;
		elapsed_d   = elapsed_q;
		tok_d       = tok_in;
		hit         = 1'b0;
		elapsed_inc = elapsed_q + 32'd1;
		match       = (tok_in.id == MY_ID);
		if (tok_in.vld) begin
			case (tok_in.op)
				REQ_CREATE: begin
					// first free slot down the row claims the request
					if (!tok_in.found && (status_q inside {ST_IDLE, ST_DELETED})) begin
						status_d    = ST_CREATED;
						period_d    = '0;
						elapsed_d   = '0;
						tok_d.found = 1'b1;
						tok_d.got   = MY_ID;
					end
				end
				REQ_START: begin
					if (match && tok_in.period != '0) begin
						status_d  = ST_RUNNING;
						period_d  = tok_in.period;
						elapsed_d = '0;
					end
				end
				REQ_STOP: begin
					if (match)
						status_d = ST_STOPPED;
				end
				REQ_DELETE: begin
					if (match)
						status_d = ST_DELETED;
				end
				REQ_QUERY: begin
					if (match)
						tok_d.run = (status_q == ST_RUNNING);
				end
				REQ_SCHED: begin
					if (status_q == ST_RUNNING) begin
						if (elapsed_inc >= period_q) begin
							status_d  = ST_STOPPED;
							elapsed_d = '0;
							hit       = 1'b1;
						end else begin
							elapsed_d = elapsed_inc;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= ST_IDLE;
			tok_q    <= '0;
		end else begin
			status_q <= status_d;
			tok_q    <= tok_d;
		end
	end

	always_ff @(posedge clk) begin
		period_q  <= period_d;
		elapsed_q <= elapsed_d;
	end

endmodule

// ===== design/otp_ctrl.sv =====
// Request sequencer: tick ring, launch into the cell row, result ordering.
`include "one_shot_timer_pool_unit_assert.svh"

module otp_ctrl #(
	parameter int TIMERS     = 16,
	parameter int TICK_QUEUE = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  logic [2:0]    req_type,
	input  logic [7:0]    timer_id,
	input  logic [31:0]   period_ticks,
	output otp_pkg::tok_t launch_q,
	input  otp_pkg::tok_t end_tok,
	input  logic          hit_any,
	output logic          strobe,
	output logic [1:0]    kind,
	output logic [7:0]    out_id,
	output logic          running,
	output logic          last
);
	import otp_pkg::*;

	localparam int IW = (TIMERS > 1) ? $clog2(TIMERS) : 1;
	localparam int RW = $clog2(TICK_QUEUE);

	function automatic logic [RW-1:0] ring_next(input logic [RW-1:0] p);
		return (p == RW'(TICK_QUEUE - 1)) ? '0 : RW'(p + 1'b1);
	endfunction

	ctl_state_t      state_q, state_d;
	tok_t            launch_d;
	logic [RW-1:0]   head_q, head_d, tail_q, tail_d, tail_nx;
	logic [IW-1:0]   pos_q, pos_d;
	logic            pend_vld_q, pend_vld_d;
	logic [IW-1:0]   pend_id_q, pend_id_d;
	logic            emit;
	logic [1:0]      emit_kind;
	logic [ID_W-1:0] emit_id;
	logic            emit_run, emit_last;
	logic            strobe_q;
	logic [1:0]      kind_q;
	logic [ID_W-1:0] out_id_q;
	logic            running_q, last_q;

	assign busy    = (state_q != CS_IDLE);
	assign strobe  = strobe_q;
	assign kind    = kind_q;
	assign out_id  = out_id_q;
	assign running = running_q;
	assign last    = last_q;

	always_comb begin
		state_d         = state_q;
		head_d          = head_q;
		tail_d          = tail_q;
		tail_nx         = ring_next(tail_q);
		pos_d           = pos_q;
		pend_vld_d      = pend_vld_q;
		pend_id_d       = pend_id_q;
		launch_d.vld    = 1'b0;
		launch_d.op     = req_t'(req_type);
		launch_d.id     = timer_id;
		launch_d.period = period_ticks;
		launch_d.found  = 1'b0;
		launch_d.got    = NO_SLOT;
		launch_d.run    = 1'b0;
		emit            = 1'b0;
		emit_kind       = KIND_EXPIRE;
		emit_id         = '0;
		emit_run        = 1'b0;
		emit_last       = 1'b0;
		case (state_q)
			CS_IDLE: begin
				pos_d = '0;
				if (start) begin
					case (req_type)
						REQ_CREATE, REQ_START, REQ_STOP, REQ_DELETE, REQ_QUERY: begin
							launch_d.vld = 1'b1;
							state_d      = CS_PASS;
						end
						REQ_TICK: begin
							// full ring: drop the oldest pending tick
							tail_d = tail_nx;
							if (tail_nx == head_q)
								head_d = ring_next(head_q);
						end
						REQ_SCHED: begin
							if (head_q != tail_q) begin
								head_d       = ring_next(head_q);
								launch_d.vld = 1'b1;
								state_d      = CS_PASS;
							end
						end
						default: ;
					endcase
				end
			end
			CS_PASS: begin
				pos_d = IW'(pos_q + 1'b1);
				// hold each expiry one slot back so the final one can carry last
				if (hit_any) begin
					if (pend_vld_q) begin
						emit    = 1'b1;
						emit_id = ID_W'(pend_id_q);
					end
					pend_vld_d = 1'b1;
					pend_id_d  = pos_q;
				end
				if (end_tok.vld) begin
					state_d    = CS_IDLE;
					pend_vld_d = 1'b0;
					case (end_tok.op)
						REQ_CREATE: begin
							emit      = 1'b1;
							emit_kind = KIND_CREATE;
							emit_id   = end_tok.got;
							emit_last = 1'b1;
						end
						REQ_QUERY: begin
							emit      = 1'b1;
							emit_kind = KIND_QUERY;
							emit_id   = end_tok.id;
							emit_run  = end_tok.run;
							emit_last = 1'b1;
						end
						REQ_SCHED: begin
							if (pend_vld_q) begin
								emit      = 1'b1;
								emit_id   = ID_W'(pend_id_q);
								emit_last = 1'b1;
							end
						end
						default: ;
					endcase
				end
			end
			default: state_d = CS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= CS_IDLE;
			head_q     <= '0;
			tail_q     <= '0;
			pos_q      <= '0;
			pend_vld_q <= 1'b0;
			launch_q   <= '0;
			strobe_q   <= 1'b0;
		end else begin
			state_q    <= state_d;
			head_q     <= head_d;
			tail_q     <= tail_d;
			pos_q      <= pos_d;
			pend_vld_q <= pend_vld_d;
			launch_q   <= launch_d;
			strobe_q   <= emit;
		end
	end

	always_ff @(posedge clk) begin
		pend_id_q <= pend_id_d;
		kind_q    <= emit_kind;
		out_id_q  <= emit_id;
		running_q <= emit_run;
		last_q    <= emit_last;
	end

	`OTP_ASSERT_SAME(a_hit_in_pass, hit_any, state_q == CS_PASS, "expiry outside a pass")
	`OTP_ASSERT_SAME(a_end_in_pass, end_tok.vld, state_q == CS_PASS, "request left row while idle")
	`OTP_ASSERT_SAME(a_pend_in_pass, pend_vld_q, state_q == CS_PASS, "expiry held after pass")
	`OTP_ASSERT_SAME(a_mid_result_busy, strobe_q && !last_q, state_q == CS_PASS,
		"non-final result after pass end")
	`OTP_ASSERT_NEXT(a_tick_moves_tail, state_q == CS_IDLE && start && req_type == REQ_TICK,
		tail_q != $past(tail_q), "tick did not advance ring tail")

endmodule

// ===== design/one_shot_timer_pool_unit.sv =====
// One-shot timer pool: sequencer feeding a row of timer cells.
// Requests that touch timers (create, start, stop, delete, query, schedule with a
// pending tick) walk the cell row one cell per cycle: busy stays high until the
// request leaves the row, and no new request is taken meanwhile. Create/query
// answers strobe once the request leaves the row. Expiries strobe in ascending
// id order as the walk goes; the final one carries last. Tick, schedule on an
// empty ring and unused codes start no walk and give nothing.
// arst_n clears all timers to idle, empties the tick ring and drops any request.
module one_shot_timer_pool_unit #(
	parameter int TIMERS     = 16,
	parameter int TICK_QUEUE = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  req_type,
	input  logic [7:0]  timer_id,
	input  logic [31:0] period_ticks,
	output logic        strobe,
	output logic [1:0]  kind,
	output logic [7:0]  out_id,
	output logic        running,
	output logic        last
);
	import otp_pkg::*;

	tok_t              chain [TIMERS+1];
	logic [TIMERS-1:0] hit_vec;

	otp_ctrl #(
		.TIMERS     (TIMERS),
		.TICK_QUEUE (TICK_QUEUE)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req_type     (req_type),
		.timer_id     (timer_id),
		.period_ticks (period_ticks),
		.launch_q     (chain[0]),
		.end_tok      (chain[TIMERS]),
		.hit_any      (|hit_vec),
		.strobe       (strobe),
		.kind         (kind),
		.out_id       (out_id),
		.running      (running),
		.last         (last)
	);

	for (genvar i = 0; i < TIMERS; i++) begin : g_cell
		otp_cell #(
			.IDX (i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.tok_in (chain[i]),
			.tok_q  (chain[i+1]),
			.hit    (hit_vec[i])
		);
	end

endmodule
